// ===== rtl/core/ptlm_pkg.sv =====
package ptlm_pkg;

    localparam int MAX_MARKERS = 64;
    localparam int IDX_W       = $clog2(MAX_MARKERS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = FRAC_BITS + 1;
    localparam int SLOPE_W     = 24;
    localparam int PROD_W      = 2 * POS_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W);

    localparam logic [POS_W-1:0]   POS_ONE   = POS_W'(1) << FRAC_BITS;
    localparam logic [SLOPE_W-1:0] SLOPE_MAX = '1;

    localparam logic [2:0] CMD_RESET  = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_SETNEW = 3'd3;
    localparam logic [2:0] CMD_O2N    = 3'd4;
    localparam logic [2:0] CMD_N2O    = 3'd5;
    localparam logic [2:0] CMD_SLOPE  = 3'd6;
    localparam logic [2:0] CMD_READ   = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OLD_RANGE = 3'd1;
    localparam logic [2:0] ST_AREAS     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;
    localparam logic [2:0] ST_TOO_FEW   = 3'd5;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_RESET,
        OP_REMOVE,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   index;
        logic [POS_W-1:0]   p_old;
        logic [POS_W-1:0]   p_new;
        logic [POS_W-1:0]   ins_old;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/ptlm_cell.sv =====
module ptlm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptlm_pkg::cell_ctrl_t        ctrl,
    input  logic [ptlm_pkg::IDX_W-1:0]  id,
    input  logic [ptlm_pkg::POS_W-1:0]  left_old,
    input  logic [ptlm_pkg::POS_W-1:0]  left_new,
    input  logic                        left_ins,
    input  logic [ptlm_pkg::POS_W-1:0]  right_old,
    input  logic [ptlm_pkg::POS_W-1:0]  right_new,
    output logic [ptlm_pkg::POS_W-1:0]  old_pos,
    output logic [ptlm_pkg::POS_W-1:0]  new_pos,
    output logic                        ins_flag,
    output logic                        below_old,
    output logic                        below_new
);
    import ptlm_pkg::*;

    logic [POS_W-1:0] old_reg, old_next;
    logic [POS_W-1:0] new_reg, new_next;
    logic [POS_W-1:0] rst_val;
    logic             live;

    assign rst_val   = (id == IDX_W'(1)) ? POS_ONE : '0;
    assign live      = {1'b0, id} < ctrl.count;
    assign ins_flag  = live && (new_reg <= ctrl.p_new);
    assign below_old = live && (ctrl.p_old < old_reg);
    assign below_new = live && (ctrl.p_new < new_reg);
    assign old_pos   = old_reg;
    assign new_pos   = new_reg;

    always_comb
    begin
        old_next = old_reg;
        new_next = new_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
            end
            OP_RESET:
            begin
                old_next = rst_val;
                new_next = rst_val;
            end
            OP_REMOVE:
            begin
                if (id >= ctrl.index)
                begin
                    old_next = right_old;
                    new_next = right_new;
                end
            end
            OP_INSERT:
            begin
                if (!ins_flag)
                begin
                    if (left_ins)
                    begin
                        old_next = ctrl.ins_old;
                        new_next = ctrl.p_new;
                    end
                    else
                    begin
                        old_next = left_old;
                        new_next = left_new;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_reg <= rst_val;
            new_reg <= rst_val;
        end
        else
        begin
            old_reg <= old_next;
            new_reg <= new_next;
        end
    end

endmodule

// ===== rtl/core/ptlm_div.sv =====
module ptlm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ptlm_pkg::PROD_W-1:0]  dividend,
    input  logic [ptlm_pkg::POS_W-1:0]   divisor,
    output logic                         done,
    output logic [ptlm_pkg::PROD_W-1:0]  quotient
);
    import ptlm_pkg::*;

    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [POS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [POS_W:0]       shifted;
    logic                 fits;

    assign shifted  = {rem_reg, quo_reg[PROD_W-1]};
    assign fits     = shifted >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? POS_W'(shifted - {1'b0, dvs_reg}) : shifted[POS_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ===== rtl/core/piecewise_linear_time_map.sv =====
// channel | dir | tuser     | tdata (low bit up)
// s_*     | in  | cmd[2:0]  | index[5:0] pos_old[16:0] pos_new[16:0]
// m_*     | out | -         | mapped slope marker_old marker_new marker_count status, pad
//
// Mapping and slope commands run the 34-step restoring divider, which is
// skipped when the point has no segment.
// Reset restores the table to (0,0),(1,1) and leaves the output empty.
// One item at a time; s_tready is low until the result is loaded into the
// output register, so a stalled m side holds one beat there and one finished
// item in the core, and then the s side stalls.
module piecewise_linear_time_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // index, pos_old, pos_new
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // mapped, slope, marker_old, marker_new, marker_count, status
);
    import ptlm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RST    = 11'b00000000010,
        S_SCAN   = 11'b00000000100,
        S_PICK   = 11'b00000001000,
        S_DECIDE = 11'b00000010000,
        S_RM     = 11'b00000100000,
        S_INS    = 11'b00001000000,
        S_CALC   = 11'b00010000000,
        S_DSTART = 11'b00100000000,
        S_DWAIT  = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]       cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [POS_W-1:0] po_reg, pn_reg, ins_old_reg, ins_old_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [MAX_MARKERS-1:0] g_old_reg, g_new_reg, hot_o_reg, hot_n_reg;
    logic [MAX_MARKERS-1:0] g_old, g_new, ins_vec;

    logic [POS_W-1:0] cell_old [MAX_MARKERS];
    logic [POS_W-1:0] cell_new [MAX_MARKERS];

    logic [POS_W-1:0] xa_reg, xb_reg, ya_reg, yb_reg, qp_reg;
    logic             segok_reg;
    logic [POS_W-1:0] xa, xb, ya, yb, rd_old, rd_new;
    logic [MAX_MARKERS-1:0] sel_hot;
    logic             seg_ok;

    logic [PROD_W-1:0] dvd_reg;
    logic [POS_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic [POS_W-1:0]  dy, tq;
    logic              zero_res;

    logic              div_done;
    logic [PROD_W-1:0] div_q;

    logic [POS_W-1:0]   res_mapped_reg, res_mapped_next;
    logic [SLOPE_W-1:0] res_slope_reg, res_slope_next;
    logic [POS_W-1:0]   res_mo_reg, res_mo_next, res_mn_reg, res_mn_next;
    logic [2:0]         res_status_reg, res_status_next;

    logic        m_valid_reg;
    logic [87:0] m_data_reg;
    logic        out_free;

    cell_ctrl_t ctrl;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        ctrl.count   = count_reg;
        ctrl.index   = idx_reg;
        ctrl.p_old   = po_reg;
        ctrl.p_new   = pn_reg;
        ctrl.ins_old = ins_old_reg;
        unique case (state_reg)
            S_RST:   ctrl.op = OP_RESET;
            S_RM:    ctrl.op = OP_REMOVE;
            S_INS:   ctrl.op = OP_INSERT;
            default: ctrl.op = OP_HOLD;
        endcase
    end

    for (genvar j = 0; j < MAX_MARKERS; j++)
    begin : g_cell
        logic [POS_W-1:0] l_old, l_new, r_old, r_new;
        logic             l_ins;
        if (j == 0)
        begin : g_first
            assign l_old = '0;
            assign l_new = '0;
            assign l_ins = 1'b1;
        end
        else
        begin : g_mid
            assign l_old = cell_old[j-1];
            assign l_new = cell_new[j-1];
            assign l_ins = ins_vec[j-1];
        end
        if (j == MAX_MARKERS - 1)
        begin : g_last
            assign r_old = '0;
            assign r_new = '0;
        end
        else
        begin : g_inner
            assign r_old = cell_old[j+1];
            assign r_new = cell_new[j+1];
        end
        ptlm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .id        (IDX_W'(j)),
            .left_old  (l_old),
            .left_new  (l_new),
            .left_ins  (l_ins),
            .right_old (r_old),
            .right_new (r_new),
            .old_pos   (cell_old[j]),
            .new_pos   (cell_new[j]),
            .ins_flag  (ins_vec[j]),
            .below_old (g_old[j]),
            .below_new (g_new[j])
        );
    end

    // segment selection: hot bit marks entry i+1, the bit above entry i
    always_comb
    begin
        sel_hot = (cmd_reg == CMD_N2O) ? hot_n_reg : hot_o_reg;
        xa = '0;
        xb = '0;
        ya = '0;
        yb = '0;
        rd_old = '0;
        rd_new = '0;
        for (int j = 0; j < MAX_MARKERS; j++)
        begin
            if (sel_hot[j])
            begin
                xb |= (cmd_reg == CMD_N2O) ? cell_new[j] : cell_old[j];
                yb |= (cmd_reg == CMD_N2O) ? cell_old[j] : cell_new[j];
            end
            if (j < MAX_MARKERS - 1 && sel_hot[(j + 1) % MAX_MARKERS])
            begin
                xa |= (cmd_reg == CMD_N2O) ? cell_new[j] : cell_old[j];
                ya |= (cmd_reg == CMD_N2O) ? cell_old[j] : cell_new[j];
            end
            if (idx_reg == IDX_W'(j))
            begin
                rd_old |= cell_old[j];
                rd_new |= cell_new[j];
            end
        end
        seg_ok = (sel_hot != '0) && !sel_hot[0];
    end

    always_comb
    begin
        tq = qp_reg - xa_reg;
        if (cmd_reg == CMD_SLOPE)
        begin
            dy       = yb_reg - ya_reg;
            zero_res = !segok_reg || (xb_reg <= xa_reg) || (yb_reg < ya_reg);
        end
        else
        begin
            dy       = (yb_reg < ya_reg) ? ya_reg - yb_reg : yb_reg - ya_reg;
            zero_res = !segok_reg || (xb_reg <= xa_reg) || (qp_reg < xa_reg);
        end
    end

    ptlm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DSTART),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ins_old_next    = ins_old_reg;
        res_mapped_next = res_mapped_reg;
        res_slope_next  = res_slope_reg;
        res_mo_next     = res_mo_reg;
        res_mn_next     = res_mn_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_mapped_next = '0;
                    res_slope_next  = '0;
                    res_mo_next     = '0;
                    res_mn_next     = '0;
                    res_status_next = ST_OK;
                    state_next      = (s_tuser == CMD_RESET) ? S_RST : S_SCAN;
                end
            end
            S_RST:
            begin
                count_next = CNT_W'(2);
                state_next = S_FINISH;
            end
            S_SCAN:   state_next = S_PICK;
            S_PICK:   state_next = S_DECIDE;
            S_DECIDE:
            begin
                state_next = S_FINISH;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        ins_old_next = po_reg;
                        if (po_reg > POS_ONE)
                            res_status_next = ST_OLD_RANGE;
                        else if (hot_o_reg != hot_n_reg)
                            res_status_next = ST_AREAS;
                        else if (count_reg >= CNT_W'(MAX_MARKERS))
                            res_status_next = ST_FULL;
                        else
                            state_next = S_INS;
                    end
                    CMD_REMOVE:
                    begin
                        if (count_reg <= CNT_W'(2))
                            res_status_next = ST_TOO_FEW;
                        else if ({1'b0, idx_reg} >= count_reg)
                            res_status_next = ST_BAD_INDEX;
                        else
                            state_next = S_RM;
                    end
                    CMD_SETNEW:
                    begin
                        ins_old_next = rd_old;
                        if ({1'b0, idx_reg} >= count_reg)
                            res_status_next = ST_BAD_INDEX;
                        else
                            state_next = S_RM;
                    end
                    CMD_READ:
                    begin
                        if ({1'b0, idx_reg} >= count_reg)
                            res_status_next = ST_BAD_INDEX;
                        else
                        begin
                            res_mo_next = rd_old;
                            res_mn_next = rd_new;
                        end
                    end
                    CMD_O2N, CMD_N2O, CMD_SLOPE: state_next = S_CALC;
                    default: state_next = S_FINISH;
                endcase
            end
            S_RM:
            begin
                count_next = count_reg - 1'b1;
                state_next = (cmd_reg == CMD_SETNEW) ? S_INS : S_FINISH;
            end
            S_INS:
            begin
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_CALC:   state_next = zero_res ? S_FINISH : S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FINISH;
                    if (cmd_reg == CMD_SLOPE)
                        res_slope_next = (div_q > PROD_W'(SLOPE_MAX)) ?
                                         SLOPE_MAX : div_q[SLOPE_W-1:0];
                    else
                        res_mapped_next = neg_reg ? ya_reg - div_q[POS_W-1:0]
                                                  : ya_reg + div_q[POS_W-1:0];
                end
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= CNT_W'(2);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_FINISH && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            cmd_reg <= s_tuser;
            idx_reg <= s_tdata[5:0];
            po_reg  <= s_tdata[22:6];
            pn_reg  <= s_tdata[39:23];
        end
        g_old_reg      <= g_old;
        g_new_reg      <= g_new;
        hot_o_reg      <= g_old_reg & (~g_old_reg + 1'b1);
        hot_n_reg      <= g_new_reg & (~g_new_reg + 1'b1);
        ins_old_reg    <= ins_old_next;
        res_mapped_reg <= res_mapped_next;
        res_slope_reg  <= res_slope_next;
        res_mo_reg     <= res_mo_next;
        res_mn_reg     <= res_mn_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_DECIDE)
        begin
            xa_reg    <= xa;
            xb_reg    <= xb;
            ya_reg    <= ya;
            yb_reg    <= yb;
            qp_reg    <= (cmd_reg == CMD_N2O) ? pn_reg : po_reg;
            segok_reg <= seg_ok;
        end
        if (state_reg == S_CALC)
        begin
            dvs_reg <= xb_reg - xa_reg;
            neg_reg <= yb_reg < ya_reg;
            if (cmd_reg == CMD_SLOPE)
                dvd_reg <= PROD_W'({dy, FRAC_BITS'(0)});
            else
                dvd_reg <= tq * dy;
        end
        if (state_reg == S_FINISH && out_free)
            m_data_reg <= {3'b000, res_status_reg, count_reg, res_mn_reg, res_mo_reg,
                           res_slope_reg, res_mapped_reg};
    end

endmodule

// ===== rtl/core/ptlm_checker.sv =====
module ptlm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);
    import ptlm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[81:75] >= 7'd2 && m_tdata[81:75] <= 7'(MAX_MARKERS))
        else $error("marker count out of range");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[84:82] <= ST_TOO_FEW)
        else $error("unknown status");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[84:82] != ST_OK |-> m_tdata[74:0] == '0)
        else $error("data with error status");

endmodule

bind piecewise_linear_time_map ptlm_checker u_ptlm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptlm_pkg::*;

    localparam int ITEMS      = 1650;
    localparam int QUIET_FROM = ITEMS - 200;
    localparam int HOLD_AT    = 400;
    localparam int DRAIN_AT   = 800;
    localparam int HOLD_LEN   = 400;
    localparam int STALL_MAX  = 20000;

    typedef struct {
        logic [16:0] mapped;
        logic [23:0] slope;
        logic [16:0] mk_old;
        logic [16:0] mk_new;
        logic [6:0]  count;
        logic [2:0]  status;
    } result_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [5:0]  idx;
        logic [16:0] p_old;
        logic [16:0] p_new;
        bit          typed;
        result_t     res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // index, pos_old, pos_new
    logic [2:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // mapped, slope, marker_old, marker_new, marker_count, status

    logic [16:0] tbl_old [MAX_MARKERS];
    logic [16:0] tbl_new [MAX_MARKERS];
    int          tbl_cnt;

    result_t     pending_q [$];
    row_t        rows [$];
    int          errors;
    int          idle_cycles;
    bit          quiet;
    bit          hold_req;

    piecewise_linear_time_map DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic void table_clear();
        for (int j = 0; j < MAX_MARKERS; j++)
        begin
            tbl_old[j] = '0;
            tbl_new[j] = '0;
        end
        tbl_old[1] = POS_ONE;
        tbl_new[1] = POS_ONE;
        tbl_cnt    = 2;
    endfunction

    function automatic int segment_of(bit by_new, logic [16:0] p);
        for (int i = 0; i < tbl_cnt; i++)
        begin
            if (p < (by_new ? tbl_new[i] : tbl_old[i]))
                return i - 1;
        end
        return tbl_cnt - 1;
    endfunction

    function automatic logic [16:0] interpolate(bit by_new, logic [16:0] p);
        int a;
        longint unsigned x0, x1, y0, y1, q;
        a = segment_of(by_new, p);
        if (a < 0 || a + 1 >= tbl_cnt)
            return '0;
        x0 = by_new ? tbl_new[a] : tbl_old[a];
        x1 = by_new ? tbl_new[a+1] : tbl_old[a+1];
        y0 = by_new ? tbl_old[a] : tbl_new[a];
        y1 = by_new ? tbl_old[a+1] : tbl_new[a+1];
        if (x1 <= x0 || p < x0)
            return '0;
        if (y1 >= y0)
        begin
            q = (p - x0) * (y1 - y0) / (x1 - x0);
            return 17'(y0 + q);
        end
        q = (p - x0) * (y0 - y1) / (x1 - x0);
        return 17'(y0 - q);
    endfunction

    function automatic logic [23:0] slope_at(logic [16:0] p);
        int a;
        longint unsigned q;
        a = segment_of(1'b0, p);
        if (a < 0 || a + 1 >= tbl_cnt)
            return '0;
        if (tbl_old[a+1] <= tbl_old[a] || tbl_new[a+1] < tbl_new[a])
            return '0;
        q = (longint'(tbl_new[a+1] - tbl_new[a]) << FRAC_BITS)
            / longint'(tbl_old[a+1] - tbl_old[a]);
        return (q > SLOPE_MAX) ? SLOPE_MAX : 24'(q);
    endfunction

    function automatic void insert_marker(logic [16:0] o, logic [16:0] n);
        int p;
        p = 0;
        while (p < tbl_cnt && tbl_new[p] <= n)
            p++;
        if (tbl_cnt >= MAX_MARKERS)
            return;
        for (int j = tbl_cnt; j > p; j--)
        begin
            tbl_old[j] = tbl_old[j-1];
            tbl_new[j] = tbl_new[j-1];
        end
        tbl_old[p] = o;
        tbl_new[p] = n;
        tbl_cnt++;
    endfunction

    function automatic void remove_marker(int p);
        for (int j = p; j + 1 < tbl_cnt; j++)
        begin
            tbl_old[j] = tbl_old[j+1];
            tbl_new[j] = tbl_new[j+1];
        end
        tbl_cnt--;
    endfunction

    function automatic result_t apply_command(logic [2:0] cmd, logic [5:0] idx,
                                              logic [16:0] po, logic [16:0] pn);
        result_t r;
        logic [16:0] keep;
        r = '{default: '0};
        r.status = ST_OK;
        case (cmd)
            CMD_RESET: table_clear();
            CMD_ADD:
            begin
                if (po > POS_ONE)
                    r.status = ST_OLD_RANGE;
                else if (segment_of(1'b0, po) != segment_of(1'b1, pn))
                    r.status = ST_AREAS;
                else if (tbl_cnt >= MAX_MARKERS)
                    r.status = ST_FULL;
                else
                    insert_marker(po, pn);
            end
            CMD_REMOVE:
            begin
                if (tbl_cnt <= 2)
                    r.status = ST_TOO_FEW;
                else if (idx >= tbl_cnt)
                    r.status = ST_BAD_INDEX;
                else
                    remove_marker(idx);
            end
            CMD_SETNEW:
            begin
                if (idx >= tbl_cnt)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    keep = tbl_old[idx];
                    remove_marker(idx);
                    insert_marker(keep, pn);
                end
            end
            CMD_O2N:   r.mapped = interpolate(1'b0, po);
            CMD_N2O:   r.mapped = interpolate(1'b1, pn);
            CMD_SLOPE: r.slope = slope_at(po);
            default:
            begin
                if (idx >= tbl_cnt)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    r.mk_old = tbl_old[idx];
                    r.mk_new = tbl_new[idx];
                end
            end
        endcase
        r.count = 7'(tbl_cnt);
        return r;
    endfunction

    function automatic void add_row(logic [2:0] cmd, logic [5:0] idx, logic [16:0] po,
                                    logic [16:0] pn, bit typed = 0,
                                    logic [16:0] mapped = 0, logic [23:0] slope = 0,
                                    logic [16:0] mo = 0, logic [16:0] mn = 0,
                                    logic [6:0] cnt = 0, logic [2:0] st = ST_OK);
        row_t r;
        r.cmd   = cmd;
        r.idx   = idx;
        r.p_old = po;
        r.p_new = pn;
        r.typed = typed;
        r.res   = '{mapped, slope, mo, mn, cnt, st};
        rows.push_back(r);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    // one beat; predictor updated on acceptance
    task automatic send(row_t r);
        result_t want;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {r.p_new, r.p_old, r.idx};
        do
            @(posedge clk);
        while (!s_tready);
        want = apply_command(r.cmd, r.idx, r.p_old, r.p_new);
        pending_q.push_back(r.typed ? r.res : want);
    endtask

    function automatic logic [16:0] rand_pos();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return '0;
        if (k == 1)
            return POS_ONE;
        if (k < 4)
            return 17'($urandom_range(0, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic row_t random_row();
        row_t r;
        int k, a;
        r.typed = 0;
        r.res   = '{default: '0};
        r.p_old = rand_pos();
        r.p_new = rand_pos();
        r.idx   = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, tbl_cnt - 1))
                                               : 6'($urandom_range(0, 63));
        k = $urandom_range(0, 99);
        if (k < 1)
            r.cmd = CMD_RESET;
        else if (k < 32)
        begin
            r.cmd = CMD_ADD;
            if ($urandom_range(0, 4) != 0)
            begin
                r.p_old = 17'($urandom_range(0, 65536));
                a = segment_of(1'b0, r.p_old);
                if (a >= 0 && a + 1 < tbl_cnt && tbl_new[a+1] > tbl_new[a])
                    r.p_new = 17'($urandom_range(tbl_new[a], tbl_new[a+1] - 1));
            end
        end
        else if (k < 44)
            r.cmd = CMD_REMOVE;
        else if (k < 54)
            r.cmd = CMD_SETNEW;
        else if (k < 66)
            r.cmd = CMD_O2N;
        else if (k < 76)
            r.cmd = CMD_N2O;
        else if (k < 88)
            r.cmd = CMD_SLOPE;
        else
            r.cmd = CMD_READ;
        return r;
    endfunction

    // receiver side
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
                report("unexpected beat", m_tdata[63:0], 0);
            else
            begin
                result_t w;
                w = pending_q.pop_front();
                if (m_tdata[16:0] !== w.mapped)
                    report("mapped", m_tdata[16:0], w.mapped);
                if (m_tdata[40:17] !== w.slope)
                    report("slope", m_tdata[40:17], w.slope);
                if (m_tdata[57:41] !== w.mk_old)
                    report("marker_old", m_tdata[57:41], w.mk_old);
                if (m_tdata[74:58] !== w.mk_new)
                    report("marker_new", m_tdata[74:58], w.mk_new);
                if (m_tdata[81:75] !== w.count)
                    report("marker_count", m_tdata[81:75], w.count);
                if (m_tdata[84:82] !== w.status)
                    report("status", m_tdata[84:82], w.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("piecewise_linear_time_map verification failed");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        idle_cycles = 0;
        quiet       = 0;
        hold_req    = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_RESET;
        table_clear();

        add_row(CMD_READ, 0, 0, 0, 1, 0, 0, 0, 0, 2, ST_OK);
        add_row(CMD_READ, 1, 0, 0, 1, 0, 0, POS_ONE, POS_ONE, 2, ST_OK);
        add_row(CMD_READ, 63, 0, 0, 1, 0, 0, 0, 0, 2, ST_BAD_INDEX);
        add_row(CMD_REMOVE, 1, 0, 0, 1, 0, 0, 0, 0, 2, ST_TOO_FEW);
        add_row(CMD_ADD, 0, 65537, 0, 1, 0, 0, 0, 0, 2, ST_OLD_RANGE);
        add_row(CMD_ADD, 0, 131071, 131071, 1, 0, 0, 0, 0, 2, ST_OLD_RANGE);
        add_row(CMD_O2N, 0, 0, 0);
        add_row(CMD_O2N, 0, POS_ONE, 0, 1, 0, 0, 0, 0, 2, ST_OK);
        add_row(CMD_N2O, 0, 0, 131071, 1, 0, 0, 0, 0, 2, ST_OK);
        add_row(CMD_SLOPE, 0, 0, 0, 1, 0, 24'h010000, 0, 0, 2, ST_OK);
        add_row(CMD_ADD, 0, 17'h08000, 17'h04000);
        add_row(CMD_ADD, 0, 17'h01000, 17'h0F000, 1, 0, 0, 0, 0, 3, ST_AREAS);
        add_row(CMD_O2N, 0, 17'h0C000, 0);
        add_row(CMD_N2O, 0, 0, 17'h02000);
        add_row(CMD_SETNEW, 1, 0, 131071);
        add_row(CMD_O2N, 0, 17'h04000, 0);
        add_row(CMD_N2O, 0, 0, 17'h0F000);
        add_row(CMD_SLOPE, 0, 17'h0C000, 0);
        add_row(CMD_REMOVE, 63, 0, 0, 1, 0, 0, 0, 0, 3, ST_BAD_INDEX);
        add_row(CMD_REMOVE, 2, 0, 0);
        add_row(CMD_RESET, 0, 131071, 131071, 1, 0, 0, 0, 0, 2, ST_OK);
        // steep first segment saturates the slope
        add_row(CMD_ADD, 0, 1, 17'h08000);
        add_row(CMD_SLOPE, 0, 0, 0, 1, 0, SLOPE_MAX, 0, 0, 3, ST_OK);
        add_row(CMD_RESET, 0, 0, 0);
        // fill past capacity along the identity line
        for (int k = 1; k <= 66; k++)
            add_row(CMD_ADD, 0, 17'(k * 900), 17'(k * 900));
        add_row(CMD_READ, 63, 0, 0);

        repeat (10) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        for (int n = 0; n < ITEMS; n++)
        begin
            if (n == HOLD_AT)
                hold_req = 1;
            if (n == DRAIN_AT)
            begin
                s_tvalid <= 1'b0;
                while (pending_q.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            if (n == QUIET_FROM)
                quiet = 1;
            send(n < rows.size() ? rows[n] : random_row());
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("piecewise_linear_time_map verification clean");
        else
            $display("piecewise_linear_time_map verification failed");
        $finish;
    end

endmodule
